// ===== design/bpt_pkg.sv =====
package bpt_pkg;

  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int PAIR_W = KEY_W + VAL_W;
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 3;
  localparam int ST_W   = 2;
  localparam int TOT_W  = 4;

  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP   = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic            load;
    logic            scan_step;
    logic            fetch;
    logic            grab;
    logic            shift_step;
    logic            append;
    logic            dec;
    logic            finish;
    logic [ST_W-1:0] code;
  } ctl_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             allow_dup;
    logic             full;
    logic             range_err;
    logic             scan_end;
    logic             shift_end;
    logic             match;
    logic             wr_pending;
    logic             out_free;
  } dp_sts_t;

endpackage

// ===== design/bpt_ifs.sv =====
interface bpt_item_if;
  logic                             valid;
  logic                             ready;
  logic [bpt_pkg::ACT_W-1:0]        action;
  logic signed [bpt_pkg::KEY_W-1:0] key;
  logic signed [bpt_pkg::VAL_W-1:0] value;
  logic [bpt_pkg::IDX_W-1:0]        index;

  modport source (output valid, action, key, value, index, input ready);
  modport sink (input valid, action, key, value, index, output ready);
endinterface

interface bpt_result_if;
  logic                             valid;
  logic                             ready;
  logic [bpt_pkg::ST_W-1:0]         status;
  logic signed [bpt_pkg::KEY_W-1:0] key_out;
  logic signed [bpt_pkg::VAL_W-1:0] value_out;
  logic [bpt_pkg::TOT_W-1:0]        entry_total;

  modport source (output valid, status, key_out, value_out, entry_total, input ready);
  modport sink (input valid, status, key_out, value_out, entry_total, output ready);
endinterface

interface bpt_cfg_if;
  logic valid;
  logic ready;
  logic allow_duplicates;

  modport source (output valid, allow_duplicates, input ready);
  modport sink (input valid, allow_duplicates, output ready);
endinterface

// ===== design/bounded_pair_table_top.sv =====
// Ordered table of up to CAPACITY key/value pairs held in a memory with one
// write and one read port, one item at a time. Every item gives exactly one
// result carrying a status and the number of pairs held afterwards. An
// out-of-range index, an unused action or an add with duplicates allowed goes
// from the decide state straight to the finish state; a read passes through
// the grab state on the way. With duplicates barred, an add first walks the
// table, one entry a cycle. A removal at index i grabs that pair, then moves
// each entry above it down one place, one entry per cycle through the memory
// ports, and waits for the last write when any entry moves. The next item is
// accepted the cycle after the previous one has been placed in the output
// register, even if that result has not yet been taken; a result still
// waiting there holds the following one back. The table contents need no
// clearing after reset: only entries below the count are ever read.
module bounded_pair_table_top #(
  parameter int CAPACITY = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  bpt_item_if.sink     in_ch,
  bpt_result_if.source out_ch,
  bpt_cfg_if.sink      cfg_ch
);

  bpt_pkg::ctl_cmd_t cmd;
  bpt_pkg::dp_sts_t  sts;
  logic              in_rdy;

  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  bpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_action            (in_ch.action),
    .in_key               (in_ch.key),
    .in_value             (in_ch.value),
    .in_index             (in_ch.index),
    .cfg_valid            (cfg_ch.valid),
    .cfg_allow_duplicates (cfg_ch.allow_duplicates),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_status           (out_ch.status),
    .out_key_out          (out_ch.key_out),
    .out_value_out        (out_ch.value_out),
    .out_entry_total      (out_ch.entry_total)
  );

  // One item at a time: nothing new is taken in the cycle after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while another was in progress");

  // A rejected or out-of-range item never reports a pair.
  a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != bpt_pkg::ST_OK
      |-> out_ch.key_out == '0 && out_ch.value_out == '0)
    else $error("pair reported on a failed item");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !sts.full)
    else $error("append into a full table");

  // At most one table operation is commanded per cycle.
  a_port_use: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.append, cmd.scan_step, cmd.fetch, cmd.shift_step, cmd.dec}))
    else $error("conflicting table operations");

endmodule

// ===== design/bpt_ctrl.sv =====
module bpt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bpt_pkg::dp_sts_t   sts,
  output bpt_pkg::ctl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_GRAB   = 3'd3;
  localparam logic [2:0] S_SHIFT  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]                  state_r;
  logic [2:0]                  state_nxt;
  logic [bpt_pkg::ST_W-1:0]    code_r;
  logic [bpt_pkg::ST_W-1:0]    code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= bpt_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.code  = code_r;
    state_nxt = state_r;
    code_nxt  = code_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.action)
          bpt_pkg::ACT_ADD: begin
            if (!sts.allow_dup) begin
              state_nxt = S_SCAN;
            end else if (sts.full) begin
              code_nxt  = bpt_pkg::ST_FULL;
              state_nxt = S_FIN;
            end else begin
              cmd.append = 1'b1;
              code_nxt   = bpt_pkg::ST_OK;
              state_nxt  = S_FIN;
            end
          end
          bpt_pkg::ACT_REMOVE, bpt_pkg::ACT_READ: begin
            if (sts.range_err) begin
              code_nxt  = bpt_pkg::ST_RANGE;
              state_nxt = S_FIN;
            end else begin
              cmd.fetch = 1'b1;
              state_nxt = S_GRAB;
            end
          end
          default: begin
            code_nxt  = bpt_pkg::ST_OK;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        // A compare lands in the cycle after its read; the scan is over once the
        // pointer has reached the count and the last compare has missed.
        if (sts.match) begin
          code_nxt  = bpt_pkg::ST_DUP;
          state_nxt = S_FIN;
        end else if (sts.scan_end) begin
          if (sts.full) begin
            code_nxt = bpt_pkg::ST_FULL;
          end else begin
            cmd.append = 1'b1;
            code_nxt   = bpt_pkg::ST_OK;
          end
          state_nxt = S_FIN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_GRAB: begin
        cmd.grab = 1'b1;
        code_nxt = bpt_pkg::ST_OK;
        if (sts.action == bpt_pkg::ACT_READ) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.shift_end) begin
          if (!sts.wr_pending) begin
            cmd.dec   = 1'b1;
            state_nxt = S_FIN;
          end
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/bpt_datapath.sv =====
module bpt_datapath #(
  parameter int CAPACITY = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bpt_pkg::ctl_cmd_t                cmd,
  output bpt_pkg::dp_sts_t                 sts,
  input  logic [bpt_pkg::ACT_W-1:0]        in_action,
  input  logic signed [bpt_pkg::KEY_W-1:0] in_key,
  input  logic signed [bpt_pkg::VAL_W-1:0] in_value,
  input  logic [bpt_pkg::IDX_W-1:0]        in_index,
  input  logic                             cfg_valid,
  input  logic                             cfg_allow_duplicates,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bpt_pkg::ST_W-1:0]         out_status,
  output logic signed [bpt_pkg::KEY_W-1:0] out_key_out,
  output logic signed [bpt_pkg::VAL_W-1:0] out_value_out,
  output logic [bpt_pkg::TOT_W-1:0]        out_entry_total
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW = (CW > bpt_pkg::IDX_W) ? CW : bpt_pkg::IDX_W;
  localparam int TW = (CW > bpt_pkg::TOT_W) ? CW : bpt_pkg::TOT_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [bpt_pkg::PAIR_W-1:0] mem [CAPACITY];
  logic [bpt_pkg::PAIR_W-1:0] rd_data_r;
  logic                       cmp_valid_r;
  logic                       wr_pending_r;
  logic [AW-1:0]              wr_addr_r;
  logic [CW-1:0]              ptr_r;
  logic [CW-1:0]              count_r;
  logic [bpt_pkg::ACT_W-1:0]  act_r;
  logic [bpt_pkg::KEY_W-1:0]  key_r;
  logic [bpt_pkg::VAL_W-1:0]  value_r;
  logic [bpt_pkg::IDX_W-1:0]  idx_r;
  logic                       allow_dup_r;
  logic [bpt_pkg::KEY_W-1:0]  res_key_r;
  logic [bpt_pkg::VAL_W-1:0]  res_val_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [bpt_pkg::ST_W-1:0]   out_status_r;
  logic [bpt_pkg::KEY_W-1:0]  out_key_r;
  logic [bpt_pkg::VAL_W-1:0]  out_val_r;
  logic [bpt_pkg::TOT_W-1:0]  out_total_r;

  logic [CW:0]                ptr_inc;
  logic [XW-1:0]              idx_ext;
  logic [XW-1:0]              in_idx_ext;
  logic [XW-1:0]              cnt_cmp;
  logic [TW-1:0]              cnt_ext;
  logic [AW-1:0]              rd_addr;
  logic                       rd_en;

  assign ptr_inc    = {1'b0, ptr_r} + (CW + 1)'(1);
  assign idx_ext    = XW'(idx_r);
  assign in_idx_ext = XW'(in_index);
  assign cnt_cmp    = XW'(count_r);
  assign cnt_ext    = TW'(count_r);
  assign rd_en      = cmd.scan_step | cmd.fetch | cmd.shift_step;
  assign rd_addr    = cmd.shift_step ? ptr_inc[AW-1:0] : ptr_r[AW-1:0];

  always_comb begin
    sts            = '0;
    sts.action     = act_r;
    sts.allow_dup  = allow_dup_r;
    sts.full       = (count_r >= CAP_CNT);
    sts.range_err  = (idx_ext >= cnt_cmp);
    sts.scan_end   = (ptr_r >= count_r);
    sts.shift_end  = (ptr_inc >= {1'b0, count_r});
    sts.match      = cmp_valid_r && (rd_data_r == {key_r, value_r});
    sts.wr_pending = wr_pending_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Table memory: one write and one registered read per cycle. During a
  // removal the write of entry i lands while entry i + 2 is being read.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[count_r[AW-1:0]] <= {key_r, value_r};
    end else if (wr_pending_r) begin
      mem[wr_addr_r] <= rd_data_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      key_r   <= in_key;
      value_r <= in_value;
      idx_r   <= in_index;
    end
    if (cmd.load) begin
      ptr_r <= (in_action == bpt_pkg::ACT_ADD) ? '0 : in_idx_ext[CW-1:0];
    end else if (cmd.scan_step || cmd.shift_step) begin
      ptr_r <= ptr_inc[CW-1:0];
    end
    if (cmd.shift_step) begin
      wr_addr_r <= ptr_r[AW-1:0];
    end
    if (cmd.load) begin
      res_key_r <= '0;
      res_val_r <= '0;
    end else if (cmd.grab) begin
      res_key_r <= rd_data_r[bpt_pkg::PAIR_W-1:bpt_pkg::VAL_W];
      res_val_r <= rd_data_r[bpt_pkg::VAL_W-1:0];
    end
    if (cmd.finish) begin
      out_status_r <= cmd.code;
      out_key_r    <= res_key_r;
      out_val_r    <= res_val_r;
      out_total_r  <= cnt_ext[bpt_pkg::TOT_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      allow_dup_r  <= 1'b1;
      cmp_valid_r  <= 1'b0;
      wr_pending_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cmp_valid_r  <= cmd.scan_step;
      wr_pending_r <= cmd.shift_step;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        allow_dup_r <= cfg_allow_duplicates;
      end
      if (cmd.append) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_key_out     = out_key_r;
  assign out_value_out   = out_val_r;
  assign out_entry_total = out_total_r;

endmodule

// ===== verif/tb.sv =====
module tb;

  localparam int CAP = 8;
  localparam int IW  = bpt_pkg::IDX_W;
  localparam int TW  = bpt_pkg::TOT_W;
  localparam logic [bpt_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [bpt_pkg::ACT_W-1:0]        action;
    logic signed [bpt_pkg::KEY_W-1:0] key;
    logic signed [bpt_pkg::VAL_W-1:0] value;
    logic [bpt_pkg::IDX_W-1:0]        index;
  } table_op_t;

  typedef struct packed {
    logic [bpt_pkg::ST_W-1:0]         status;
    logic signed [bpt_pkg::KEY_W-1:0] key_out;
    logic signed [bpt_pkg::VAL_W-1:0] value_out;
    logic [bpt_pkg::TOT_W-1:0]        entry_total;
  } table_reply_t;

  logic clk;
  logic rst_n;

  bpt_item_if   in_if ();
  bpt_result_if out_if ();
  bpt_cfg_if    cfg_if ();

  bounded_pair_table_top #(.CAPACITY(CAP)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow of the table, kept in step with accepted items.
  logic signed [bpt_pkg::KEY_W-1:0] shadow_key [CAP];
  logic signed [bpt_pkg::VAL_W-1:0] shadow_val [CAP];
  int                               shadow_count = 0;
  bit                               dup_ok = 1'b1;

  table_op_t    op_queue [$];
  table_reply_t pending_replies [$];
  table_op_t    cur_op;
  table_reply_t want;

  int items_pushed   = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int fail_count     = 0;
  int src_gap        = 0;
  int snk_gap        = 0;
  int stall_left     = 0;
  bit stall_done     = 1'b0;
  bit quiet          = 1'b0;

  logic signed [bpt_pkg::KEY_W-1:0] key_pool [4];
  logic signed [bpt_pkg::VAL_W-1:0] val_pool [4];

  function automatic table_reply_t apply_table_op(input table_op_t op);
    table_reply_t r;
    bit           hit;
    r = '0;
    r.status = bpt_pkg::ST_OK;
    hit = 1'b0;
    case (op.action)
      bpt_pkg::ACT_ADD: begin
        for (int i = 0; i < shadow_count; i++)
          if (shadow_key[i] == op.key && shadow_val[i] == op.value) hit = 1'b1;
        if (!dup_ok && hit) begin
          r.status = bpt_pkg::ST_DUP;
        end else if (shadow_count >= CAP) begin
          r.status = bpt_pkg::ST_FULL;
        end else begin
          shadow_key[shadow_count] = op.key;
          shadow_val[shadow_count] = op.value;
          shadow_count++;
        end
      end
      bpt_pkg::ACT_REMOVE, bpt_pkg::ACT_READ: begin
        if (int'(op.index) >= shadow_count) begin
          r.status = bpt_pkg::ST_RANGE;
        end else begin
          r.key_out = shadow_key[op.index];
          r.value_out = shadow_val[op.index];
          if (op.action == bpt_pkg::ACT_REMOVE) begin
            for (int i = int'(op.index); i + 1 < shadow_count; i++) begin
              shadow_key[i] = shadow_key[i + 1];
              shadow_val[i] = shadow_val[i + 1];
            end
            shadow_count--;
          end
        end
      end
      default: begin
      end
    endcase
    r.entry_total = TW'(shadow_count);
    return r;
  endfunction

  task automatic push_op(input logic [bpt_pkg::ACT_W-1:0] action,
                         input logic signed [bpt_pkg::KEY_W-1:0] key,
                         input logic signed [bpt_pkg::VAL_W-1:0] value,
                         input logic [bpt_pkg::IDX_W-1:0] index);
    table_op_t op;
    op.action = action;
    op.key = key;
    op.value = value;
    op.index = index;
    op_queue.insert(op_queue.size(), op);
    items_pushed++;
  endtask

  // Keys and values are mostly drawn from a small pool so that repeated
  // pairs turn up often enough to exercise the duplicate check.
  task automatic queue_random_ops(input int n, input int add_pct, input int rem_pct);
    logic [bpt_pkg::ACT_W-1:0] act;
    int                        r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) act = bpt_pkg::ACT_ADD;
      else if (r < add_pct + rem_pct) act = bpt_pkg::ACT_REMOVE;
      else if (r < 96) act = bpt_pkg::ACT_READ;
      else act = ACT_UNUSED;
      if ($urandom_range(0, 3) == 0)
        push_op(act, $urandom, $urandom, IW'($urandom_range(0, 7)));
      else
        push_op(act, key_pool[$urandom_range(0, 3)], val_pool[$urandom_range(0, 3)],
                IW'($urandom_range(0, 7)));
    end
  endtask

  task automatic wait_idle();
    while (results_seen < items_pushed) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_dup_mode(input logic mode);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.allow_duplicates <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    dup_ok = mode;
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        pending_replies.insert(pending_replies.size(), apply_table_op(cur_op));
        items_accepted <= items_accepted + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap == 0 && !quiet && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 6);
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          in_if.valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          cur_op = op_queue.pop_front();
          in_if.valid <= 1'b1;
          in_if.action <= cur_op.action;
          in_if.key <= cur_op.key;
          in_if.value <= cur_op.value;
          in_if.index <= cur_op.index;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off part way through, while items keep coming.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (!stall_done && items_accepted >= 620) begin
      stall_left <= 400;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        if (pending_replies.size() == 0) begin
          $error("result with no item outstanding: status %0d", out_if.status);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            fail_count++;
          end
          if (out_if.key_out !== want.key_out) begin
            $error("key_out: expected %0d, got %0d", want.key_out, out_if.key_out);
            fail_count++;
          end
          if (out_if.value_out !== want.value_out) begin
            $error("value_out: expected %0d, got %0d", want.value_out, out_if.value_out);
            fail_count++;
          end
          if (out_if.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d", want.entry_total, out_if.entry_total);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap = snk_gap - 1;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(0, 5);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = bpt_pkg::ACT_ADD;
    in_if.key = '0;
    in_if.value = '0;
    in_if.index = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.allow_duplicates = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Duplicates allowed: range errors, the unused action, filling up and
    // removals at both ends of the table.
    push_op(bpt_pkg::ACT_REMOVE, 0, 0, 0);
    push_op(bpt_pkg::ACT_ADD, 32'sh8000_0000, 32'sh7fff_ffff, 0);
    push_op(bpt_pkg::ACT_ADD, 0, -1, 7);
    push_op(bpt_pkg::ACT_ADD, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    push_op(bpt_pkg::ACT_READ, 0, 0, 0);
    push_op(bpt_pkg::ACT_READ, 0, 0, 3);
    push_op(bpt_pkg::ACT_REMOVE, 0, 0, 1);
    push_op(ACT_UNUSED, -1, -1, 7);
    for (int i = 0; i < 6; i++) push_op(bpt_pkg::ACT_ADD, $urandom, $urandom, 0);
    push_op(bpt_pkg::ACT_ADD, 1, 2, 0);
    push_op(bpt_pkg::ACT_READ, 0, 0, 7);
    push_op(bpt_pkg::ACT_REMOVE, 0, 0, 7);
    push_op(bpt_pkg::ACT_REMOVE, 0, 0, 0);
    wait_idle();

    // Duplicates barred: the duplicate check wins over a full table.
    set_dup_mode(1'b0);
    push_op(bpt_pkg::ACT_ADD, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    push_op(bpt_pkg::ACT_ADD, 5, 6, 0);
    push_op(bpt_pkg::ACT_ADD, -5, -6, 0);
    push_op(bpt_pkg::ACT_ADD, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    push_op(bpt_pkg::ACT_ADD, 9, 9, 0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      set_dup_mode((p % 2) == 0);
      for (int j = 0; j < 4; j++) begin
        key_pool[j] = $urandom;
        val_pool[j] = $urandom;
      end
      if (p == 7) quiet = 1'b1;
      for (int b = 0; b < 5; b++) begin
        if (b % 2 == 0) queue_random_ops(50, 60, 15);
        else queue_random_ops(50, 25, 50);
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/bpt_pkg.sv
design/bpt_ifs.sv
design/bpt_ctrl.sv
design/bpt_datapath.sv
design/bounded_pair_table_top.sv
verif/tb.sv
